[hw/rtl/btff_pkg.sv]
// Shared types, constants and tag helpers for the boundary tag first fit allocator.
// No dependencies; every other file but btff_if and btff_tb_pkg imports this package.
`default_nettype none

package btff_pkg;

  // heap geometry
  localparam int unsigned HEAP_BYTES    = 65536;
  localparam int unsigned PAGE_BYTES    = 4096;
  localparam int unsigned INITIAL_PAGES = 1;
  localparam int unsigned WORDS         = HEAP_BYTES / 4;
  localparam int unsigned WORD_AW       = $clog2(WORDS);
  localparam int unsigned PAGE_W        = $clog2(PAGE_BYTES);

  // field and datapath widths
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned REQ_W  = 17;
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned SIZ_W  = REQ_W + 1;
  localparam int unsigned TAG_W  = 20;
  localparam int unsigned LIM_W  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned CUR_W  = 18;
  localparam int unsigned ST_W   = 3;

  // walk bound
  localparam int unsigned WALK_CAP = 2 * (HEAP_BYTES / 8) + 16;
  localparam int unsigned CNT_W    = $clog2(WALK_CAP + 1);

  localparam logic [ADDR_W-1:0] FIRST_HDR = ADDR_W'(12);
  localparam logic [LIM_W-1:0]  LIM_RESET = LIM_W'(PAGE_BYTES * INITIAL_PAGES);

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_OOM     = 3'd2,
    ST_IGN     = 3'd3,
    ST_UNALLOC = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_A_INIT,
    OP_A_RD,
    OP_A_EV,
    OP_W_SPLIT_FT,
    OP_W_SPLIT_HD,
    OP_W_ALLOC_HD,
    OP_W_ALLOC_FT,
    OP_GROW,
    OP_G_FT,
    OP_G_EPI,
    OP_C_RH,
    OP_C_RN,
    OP_C_NH,
    OP_C_NF,
    OP_C_RP,
    OP_C_PR,
    OP_C_PS,
    OP_C_PF,
    OP_F_INIT,
    OP_F_RD,
    OP_F_EV,
    OP_F_RH,
    OP_F_RF,
    OP_F_WH,
    OP_F_WF,
    OP_FIN
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_A_RD,
    S_A_EV,
    S_A_S1,
    S_A_S2,
    S_A_S3,
    S_A_S4,
    S_G1,
    S_G2,
    S_G3,
    S_C_RH,
    S_C_RN,
    S_C_NX,
    S_C_NF,
    S_C_RP,
    S_C_PV,
    S_C_PS,
    S_C_PF,
    S_F_RD,
    S_F_EV,
    S_F_HD,
    S_F_HV,
    S_F_FV,
    S_F_WH,
    S_F_WF,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    logic func_free;
    logic req_zero;
    logic off_bad;
    logic hdr_ge_hb;
    logic cnt_cap;
    logic tag_free;
    logic sz_gt;
    logic sz_eq;
    logic sz_zero;
    logic walk_end;
    logic oom;
    logic walk_go;
    logic cur_ne_hdr;
    logic hv_ne_fv;
    logic hv_alloc;
    logic out_busy;
  } dp_stat_t;

  // tag word: size in bytes over two spare bits and the allocated mark
  function automatic logic [TAG_W-1:0] mk_tag(input logic [SIZE_W-1:0] sz, input logic used);
    mk_tag = {sz, 2'b00, used};
  endfunction

  // contents of the four boot words before they are first written
  function automatic logic [TAG_W-1:0] boot_tag(input logic [1:0] w);
    case (w)
      2'd1, 2'd2: boot_tag = mk_tag(SIZE_W'(8), 1'b1);
      2'd3:       boot_tag = mk_tag('0, 1'b1);
      default:    boot_tag = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

[hw/rtl/btff_if.sv]
// Request and response channel interfaces of the allocator.
// Plain valid/ready channels; no package dependency.
`default_nettype none

interface btff_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [16:0] request_bytes;
  logic [15:0] release_offset;

  modport source (output valid, output func, output request_bytes, output release_offset,
                  input ready);
  modport sink   (input valid, input func, input request_bytes, input release_offset,
                  output ready);
endinterface

interface btff_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_offset;
  logic [2:0]  status;

  modport source (output valid, output payload_offset, output status, input ready);
  modport sink   (input valid, input payload_offset, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/btff_ctrl.sv]
// Controller state machine of the allocator: sequences walks, splits, growth and merges.
// Depends on btff_pkg; drives the datapath by one command per cycle.
`default_nettype none

module btff_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  btff_pkg::dp_stat_t     stat_i,
  output btff_pkg::dp_cmd_t      cmd_o
);
  import btff_pkg::*;

  ctrl_state_e state_q, state_d;
  status_e     st_q, st_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_CHK;
      S_CHK: begin
        if (stat_i.func_free) begin
          if (stat_i.off_bad || stat_i.hdr_ge_hb) begin
            st_d    = ST_IGN;
            state_d = S_FIN;
          end else begin
            state_d = S_F_RD;
          end
        end else if (stat_i.req_zero) begin
          st_d    = ST_ZERO;
          state_d = S_FIN;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_A_RD: begin
        if (stat_i.cnt_cap) begin
          st_d    = ST_OOM;
          state_d = S_FIN;
        end else begin
          state_d = S_A_EV;
        end
      end
      S_A_EV: begin
        if (stat_i.tag_free && stat_i.sz_gt) begin
          state_d = S_A_S1;
        end else if (stat_i.tag_free && stat_i.sz_eq) begin
          state_d = S_A_S3;
        end else if (stat_i.walk_end) begin
          if (stat_i.oom) begin
            st_d    = ST_OOM;
            state_d = S_FIN;
          end else begin
            state_d = S_G1;
          end
        end else begin
          state_d = S_A_RD;
        end
      end
      S_A_S1: state_d = S_A_S2;
      S_A_S2: state_d = S_A_S3;
      S_A_S3: state_d = S_A_S4;
      S_A_S4: begin
        st_d    = ST_OK;
        state_d = S_FIN;
      end
      S_G1:   state_d = S_G2;
      S_G2:   state_d = S_G3;
      S_G3:   state_d = S_C_RH;
      S_C_RH: state_d = S_C_RN;
      S_C_RN: state_d = S_C_NX;
      S_C_NX: state_d = (stat_i.tag_free && !stat_i.sz_zero) ? S_C_NF : S_C_RP;
      S_C_NF: state_d = S_C_RP;
      S_C_RP: state_d = S_C_PV;
      S_C_PV: begin
        if (stat_i.tag_free && !stat_i.sz_zero) begin
          state_d = S_C_PS;
        end else if (stat_i.func_free) begin
          st_d    = ST_OK;
          state_d = S_FIN;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_C_PS: state_d = S_C_PF;
      S_C_PF: begin
        if (stat_i.func_free) begin
          st_d    = ST_OK;
          state_d = S_FIN;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_F_RD: state_d = stat_i.walk_go ? S_F_EV : S_F_HD;
      S_F_EV: state_d = stat_i.sz_zero ? S_F_HD : S_F_RD;
      S_F_HD: begin
        if (stat_i.cur_ne_hdr) begin
          st_d    = ST_IGN;
          state_d = S_FIN;
        end else begin
          state_d = S_F_HV;
        end
      end
      S_F_HV: begin
        if (stat_i.sz_zero) begin
          st_d    = ST_IGN;
          state_d = S_FIN;
        end else begin
          state_d = S_F_FV;
        end
      end
      S_F_FV: begin
        if (stat_i.hv_ne_fv) begin
          st_d    = ST_IGN;
          state_d = S_FIN;
        end else if (!stat_i.hv_alloc) begin
          st_d    = ST_UNALLOC;
          state_d = S_FIN;
        end else begin
          state_d = S_F_WH;
        end
      end
      S_F_WH: state_d = S_F_WF;
      S_F_WF: state_d = S_C_RH;
      S_FIN:  if (!stat_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.st   = st_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_CHK: begin
        if (stat_i.func_free) begin
          if (!(stat_i.off_bad || stat_i.hdr_ge_hb)) cmd_o.op = OP_F_INIT;
        end else if (!stat_i.req_zero) begin
          cmd_o.op = OP_A_INIT;
        end
      end
      S_A_RD: if (!stat_i.cnt_cap) cmd_o.op = OP_A_RD;
      S_A_EV: cmd_o.op = OP_A_EV;
      S_A_S1: cmd_o.op = OP_W_SPLIT_FT;
      S_A_S2: cmd_o.op = OP_W_SPLIT_HD;
      S_A_S3: cmd_o.op = OP_W_ALLOC_HD;
      S_A_S4: cmd_o.op = OP_W_ALLOC_FT;
      S_G1:   cmd_o.op = OP_GROW;
      S_G2:   cmd_o.op = OP_G_FT;
      S_G3:   cmd_o.op = OP_G_EPI;
      S_C_RH: cmd_o.op = OP_C_RH;
      S_C_RN: cmd_o.op = OP_C_RN;
      S_C_NX: if (stat_i.tag_free && !stat_i.sz_zero) cmd_o.op = OP_C_NH;
      S_C_NF: cmd_o.op = OP_C_NF;
      S_C_RP: cmd_o.op = OP_C_RP;
      S_C_PV: if (stat_i.tag_free && !stat_i.sz_zero) cmd_o.op = OP_C_PR;
      S_C_PS: cmd_o.op = OP_C_PS;
      S_C_PF: cmd_o.op = OP_C_PF;
      S_F_RD: if (stat_i.walk_go) cmd_o.op = OP_F_RD;
      S_F_EV: if (!stat_i.sz_zero) cmd_o.op = OP_F_EV;
      S_F_HD: if (!stat_i.cur_ne_hdr) cmd_o.op = OP_F_RH;
      S_F_HV: if (!stat_i.sz_zero) cmd_o.op = OP_F_RF;
      S_F_FV: ;
      S_F_WH: cmd_o.op = OP_F_WH;
      S_F_WF: cmd_o.op = OP_F_WF;
      S_FIN:  if (!stat_i.out_busy) cmd_o.op = OP_FIN;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/btff_dp.sv]
// Datapath of the allocator: tag memory, heap break and limit, walk pointer and result word.
// Depends on btff_pkg; executes one command from btff_ctrl per cycle.
`default_nettype none

module btff_dp (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  btff_pkg::dp_cmd_t             cmd_i,
  output btff_pkg::dp_stat_t            stat_o,
  input  wire                           in_func_i,
  input  wire  [btff_pkg::REQ_W-1:0]    in_request_bytes_i,
  input  wire  [btff_pkg::ADDR_W-1:0]   in_release_offset_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [btff_pkg::ADDR_W-1:0]   out_payload_offset_o,
  output logic [btff_pkg::ST_W-1:0]     out_status_o
);
  import btff_pkg::*;

  // tag store and read register
  logic [TAG_W-1:0] mem [WORDS];
  logic [TAG_W-1:0] rd_q;
  logic [3:0]       boot_v_q;

  // control state
  logic [ADDR_W-1:0] hb_q;
  logic [LIM_W-1:0]  lim_q;
  logic              out_valid_q;

  // working registers
  logic              func_q;
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] off_q;
  logic [SIZ_W-1:0]  siz_q;
  logic [CUR_W-1:0]  cur_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SIZE_W-1:0] bs_q;
  logic [ADDR_W-1:0] hh_q;
  logic [ADDR_W-1:0] ad_q;
  logic [TAG_W-1:0]  hv_q;
  logic [ADDR_W-1:0] out_pl_q;
  status_e           out_st_q;

  logic [SIZE_W-1:0]  s;
  logic [CUR_W-1:0]   nxt;
  logic [SIZE_W:0]    sum_t;
  logic               take;
  logic [ADDR_W-1:0]  hdr;
  logic [SIZ_W:0]     oom_sum;
  logic [LIM_W-1:0]   end_v;
  logic [LIM_W-1:0]   diff;
  logic [LIM_W-1:0]   diff_up;
  logic [ADDR_W-1:0]  maddr;
  logic [WORD_AW-1:0] widx;
  logic [TAG_W-1:0]   wdata;
  logic               we;
  logic               re;

  // block size of the tag just read
  assign s       = rd_q[TAG_W-1:3];
  assign nxt     = cur_q + CUR_W'(s);
  assign sum_t   = {1'b0, s} + {1'b0, bs_q};
  assign take    = !rd_q[0] && ({1'b0, s} >= siz_q);
  assign hdr     = off_q - ADDR_W'(4);
  assign oom_sum = (SIZ_W+1)'(hb_q) + (SIZ_W+1)'(siz_q) + (SIZ_W+1)'(4);

  // new limit after growth, rounded up to whole pages
  assign end_v   = LIM_W'(hb_q) + siz_q[LIM_W-1:0];
  assign diff    = end_v - lim_q;
  assign diff_up = diff + LIM_W'(PAGE_BYTES - 1);

  // status toward the controller
  always_comb begin
    stat_o.func_free  = func_q;
    stat_o.req_zero   = (req_q == '0);
    stat_o.off_bad    = (off_q == '0) || (off_q[2:0] != 3'd0) || (LIM_W'(off_q) > lim_q);
    stat_o.hdr_ge_hb  = (hdr >= hb_q);
    stat_o.cnt_cap    = (cnt_q == CNT_W'(WALK_CAP));
    stat_o.tag_free   = !rd_q[0];
    stat_o.sz_gt      = (SIZ_W'(s) > siz_q);
    stat_o.sz_eq      = (SIZ_W'(s) == siz_q);
    stat_o.sz_zero    = (s == '0);
    stat_o.walk_end   = (s == '0) || (nxt >= CUR_W'(hb_q));
    stat_o.oom        = (oom_sum > (SIZ_W+1)'(HEAP_BYTES));
    stat_o.walk_go    = (cnt_q != CNT_W'(WALK_CAP)) && (cur_q < CUR_W'(hh_q)) &&
                        (cur_q < CUR_W'(hb_q));
    stat_o.cur_ne_hdr = (cur_q != CUR_W'(hh_q));
    stat_o.hv_ne_fv   = (hv_q != rd_q);
    stat_o.hv_alloc   = hv_q[0];
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // memory address and write data per command
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    maddr = cur_q[ADDR_W-1:0];
    wdata = '0;
    case (cmd_i.op)
      OP_A_RD, OP_F_RD: begin
        re    = 1'b1;
        maddr = cur_q[ADDR_W-1:0];
      end
      OP_W_SPLIT_FT: begin
        we    = 1'b1;
        maddr = cur_q[ADDR_W-1:0] + ADDR_W'(bs_q) - ADDR_W'(4);
        wdata = mk_tag(bs_q - siz_q[SIZE_W-1:0], 1'b0);
      end
      OP_W_SPLIT_HD: begin
        we    = 1'b1;
        maddr = cur_q[ADDR_W-1:0] + siz_q[ADDR_W-1:0];
        wdata = mk_tag(bs_q - siz_q[SIZE_W-1:0], 1'b0);
      end
      OP_W_ALLOC_HD: begin
        we    = 1'b1;
        maddr = cur_q[ADDR_W-1:0];
        wdata = mk_tag(siz_q[SIZE_W-1:0], 1'b1);
      end
      OP_W_ALLOC_FT: begin
        we    = 1'b1;
        maddr = cur_q[ADDR_W-1:0] + siz_q[ADDR_W-1:0] - ADDR_W'(4);
        wdata = mk_tag(siz_q[SIZE_W-1:0], 1'b1);
      end
      OP_GROW: begin
        we    = 1'b1;
        maddr = hb_q;
        wdata = mk_tag(siz_q[SIZE_W-1:0], 1'b0);
      end
      OP_G_FT: begin
        we    = 1'b1;
        maddr = hh_q + siz_q[ADDR_W-1:0] - ADDR_W'(4);
        wdata = mk_tag(siz_q[SIZE_W-1:0], 1'b0);
      end
      OP_G_EPI: begin
        we    = 1'b1;
        maddr = hb_q;
        wdata = mk_tag('0, 1'b1);
      end
      OP_C_RH, OP_F_RH: begin
        re    = 1'b1;
        maddr = hh_q;
      end
      OP_C_RN: begin
        re    = 1'b1;
        maddr = hh_q + ADDR_W'(s);
      end
      OP_C_NH: begin
        we    = 1'b1;
        maddr = hh_q;
        wdata = mk_tag(sum_t[SIZE_W-1:0], 1'b0);
      end
      OP_C_NF, OP_C_PF: begin
        we    = 1'b1;
        maddr = (cmd_i.op == OP_C_PF) ? (ad_q + ADDR_W'(bs_q) - ADDR_W'(4)) : ad_q;
        wdata = mk_tag(bs_q, 1'b0);
      end
      OP_C_RP: begin
        re    = 1'b1;
        maddr = hh_q - ADDR_W'(4);
      end
      OP_C_PR: begin
        re    = 1'b1;
        maddr = hh_q - ADDR_W'(s);
      end
      OP_C_PS: begin
        we    = 1'b1;
        maddr = ad_q;
        wdata = mk_tag(sum_t[SIZE_W-1:0], 1'b0);
      end
      OP_F_RF: begin
        re    = 1'b1;
        maddr = hh_q + ADDR_W'(s) - ADDR_W'(4);
      end
      OP_F_WH, OP_F_WF: begin
        we    = 1'b1;
        maddr = (cmd_i.op == OP_F_WF) ? (hh_q + ADDR_W'(bs_q) - ADDR_W'(4)) : hh_q;
        wdata = mk_tag(bs_q, 1'b0);
      end
      default: ;
    endcase
  end

  assign widx = maddr[ADDR_W-1:2];

  // single port tag store, boot words overlaid until first written
  always_ff @(posedge clk_i) begin
    if (we) mem[widx] <= wdata;
    if (re) begin
      if ((widx < WORD_AW'(4)) && !boot_v_q[widx[1:0]]) rd_q <= boot_tag(widx[1:0]);
      else rd_q <= mem[widx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_v_q <= '0;
    end else if (we && (widx < WORD_AW'(4))) begin
      boot_v_q[widx[1:0]] <= 1'b1;
    end
  end

  // heap break, limit and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q        <= FIRST_HDR;
      lim_q       <= LIM_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_GROW) begin
        hb_q <= hb_q + siz_q[ADDR_W-1:0];
        if (end_v > lim_q) begin
          lim_q <= lim_q + {diff_up[LIM_W-1:PAGE_W], PAGE_W'(0)};
        end
      end
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.op == OP_FIN) out_valid_q <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q <= in_func_i;
        req_q  <= in_request_bytes_i;
        off_q  <= in_release_offset_i;
      end
      OP_A_INIT: begin
        siz_q <= (SIZ_W'(req_q) + SIZ_W'(15)) & ~SIZ_W'(7);
        cur_q <= CUR_W'(FIRST_HDR);
        cnt_q <= '0;
      end
      OP_A_EV: begin
        bs_q  <= s;
        cnt_q <= cnt_q + CNT_W'(1);
        if (!take && !((s == '0) || (nxt >= CUR_W'(hb_q)))) cur_q <= nxt;
      end
      OP_GROW: hh_q <= hb_q;
      OP_C_RN: bs_q <= s;
      OP_C_NH: begin
        bs_q <= sum_t[SIZE_W-1:0];
        ad_q <= hh_q + ADDR_W'(sum_t) - ADDR_W'(4);
      end
      OP_C_PR: ad_q <= hh_q - ADDR_W'(s);
      OP_C_PS: bs_q <= sum_t[SIZE_W-1:0];
      OP_F_INIT: begin
        hh_q  <= hdr;
        cur_q <= CUR_W'(FIRST_HDR);
        cnt_q <= '0;
      end
      OP_F_EV: begin
        cur_q <= nxt;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      OP_F_RF: begin
        bs_q <= s;
        hv_q <= rd_q;
      end
      OP_FIN: begin
        out_st_q <= cmd_i.st;
        out_pl_q <= ((cmd_i.st == ST_OK) && !func_q) ? (cur_q[ADDR_W-1:0] + ADDR_W'(4))
                                                     : '0;
      end
      default: ;
    endcase
  end

  assign out_valid_o          = out_valid_q;
  assign out_payload_offset_o = out_pl_q;
  assign out_status_o         = out_st_q;

  // the break stays word aligned and inside the limit and the store
  a_break_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LIM_W'(hb_q) <= lim_q) else $error("heap break above limit");
  a_break_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LIM_W'(hb_q) + LIM_W'(4) <= LIM_W'(HEAP_BYTES)) && (hb_q[1:0] == 2'b00))
    else $error("heap break outside store");
  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re)) else $error("tag store read and write in one cycle");

endmodule

`default_nettype wire

[hw/rtl/boundary_tag_first_fit_allocator.sv]
// Top level of the boundary tag first fit allocator.
// Depends on btff_pkg, btff_if, btff_ctrl and btff_dp.
`default_nettype none

// One request word at a time: allocate (func 0) or free (func 1), one response word each.
// All block tags live in a single-port 16K x 20 tag memory, one access per cycle, so the
// memory port sets the time: an allocate walks the blocks from the first header, then
// writes a split or an exact fit, or grows the heap, merges and walks on; a free walks the
// blocks up to its header, then checks, retags and merges. Requests rejected at entry go
// straight to the response. A new request is taken only once the previous response is in
// the output register, which holds it until taken. No clearing pass follows reset: the
// four boot words read their reset tags until first written, and the rest of the memory
// is written before it is read.
module boundary_tag_first_fit_allocator (
  input  wire        clk_i,
  input  wire        rst_ni,
  btff_req_if.sink   req_i,
  btff_rsp_if.source rsp_o
);
  import btff_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller
  btff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  btff_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .in_func_i            (req_i.func),
    .in_request_bytes_i   (req_i.request_bytes),
    .in_release_offset_i  (req_i.release_offset),
    .out_valid_o          (rsp_o.valid),
    .out_ready_i          (rsp_o.ready),
    .out_payload_offset_o (rsp_o.payload_offset),
    .out_status_o         (rsp_o.status)
  );

endmodule

`default_nettype wire

[verif/btff_tb_pkg.sv]
// Request codes shared by the allocator testbench files.
// Depends on nothing; imported by the checker and the testbench top.
`timescale 1ns / 1ps

package btff_tb_pkg;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

endpackage

[verif/btff_checker.sv]
// Checker for the allocator: watches both channels, predicts each response word
// from its own heap image and compares. Depends on btff_pkg, btff_tb_pkg and btff_if.
`timescale 1ns / 1ps

module btff_checker
  import btff_pkg::*;
  import btff_tb_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  btff_req_if         req_i,
  btff_rsp_if         rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  typedef struct {
    logic [15:0] payload;
    status_e     st;
  } rsp_word_t;

  localparam int unsigned TAG_WORDS = HEAP_BYTES / 4;
  localparam int unsigned MAX_WALK  = 2 * (HEAP_BYTES / 8) + 16;

  // heap image
  logic [19:0] heap_tags [0:TAG_WORDS-1];
  int unsigned brk_pos;
  int unsigned lim_pos;
  int unsigned walk_head;

  rsp_word_t   want_q[$];

  assign pending_o = want_q.size();

  function automatic int unsigned tag_rd(input int unsigned a);
    return heap_tags[(a >> 2) & (TAG_WORDS - 1)];
  endfunction

  function automatic void tag_wr(input int unsigned a, input int unsigned v);
    heap_tags[(a >> 2) & (TAG_WORDS - 1)] = v[19:0];
  endfunction

  function automatic int unsigned tag_of(input int unsigned sz, input bit used);
    return (sz << 3) | used;
  endfunction

  // merge a free block with free neighbours
  function automatic void merge_free(input int unsigned h);
    int unsigned s, nh, nv, pv, ph, ns;
    s  = tag_rd(h) >> 3;
    nh = h + s;
    nv = tag_rd(nh);
    if (!nv[0] && (nv >> 3) != 0) begin
      tag_wr(h, tag_of(s + (nv >> 3), 1'b0));
      tag_wr(nh + (nv >> 3) - 4, tag_of(s + (nv >> 3), 1'b0));
    end
    pv = tag_rd(h - 4);
    if (!pv[0] && (pv >> 3) != 0) begin
      ph = h - (pv >> 3);
      ns = (tag_rd(ph) >> 3) + (tag_rd(h) >> 3);
      tag_wr(ph, tag_of(ns, 1'b0));
      tag_wr(ph + ns - 4, tag_of(ns, 1'b0));
    end
  endfunction

  // move the break up by siz bytes, limit in whole pages
  function automatic void extend_heap(input int unsigned siz);
    int unsigned h, over;
    h = brk_pos;
    if (brk_pos + siz > lim_pos) begin
      over = brk_pos + siz - lim_pos;
      lim_pos += ((over + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    end
    brk_pos = h + siz;
    tag_wr(h, tag_of(siz, 1'b0));
    tag_wr(h + siz - 4, tag_of(siz, 1'b0));
    tag_wr(brk_pos, tag_of(0, 1'b1));
    merge_free(h);
  endfunction

  function automatic rsp_word_t first_fit(input int unsigned rq);
    rsp_word_t   r;
    int unsigned siz, cur, v, s;
    r.payload = '0;
    r.st      = ST_OK;
    if (rq == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    siz = (rq + 15) & ~32'd7;
    cur = walk_head;
    for (int unsigned n = 0; n < MAX_WALK; n++) begin
      v = tag_rd(cur);
      s = v >> 3;
      if (!v[0] && s >= siz) begin
        if (s > siz) begin
          tag_wr(cur + s - 4, tag_of(s - siz, 1'b0));
          tag_wr(cur + siz, tag_of(s - siz, 1'b0));
        end
        tag_wr(cur, tag_of(siz, 1'b1));
        tag_wr(cur + siz - 4, tag_of(siz, 1'b1));
        r.payload = 16'(cur + 4);
        return r;
      end
      if (s == 0 || cur + s >= brk_pos) begin
        if (brk_pos + siz + 4 > HEAP_BYTES) begin
          r.st = ST_OOM;
          return r;
        end
        extend_heap(siz);
      end else begin
        cur = cur + s;
      end
    end
    r.st = ST_OOM;
    return r;
  endfunction

  function automatic status_e release_block(input int unsigned off);
    int unsigned hdr, c, s, hv, fv;
    if (off == 0 || (off & 7) != 0 || off > lim_pos) return ST_IGN;
    hdr = off - 4;
    if (hdr >= brk_pos) return ST_IGN;
    c = walk_head;
    for (int unsigned n = 0; n < MAX_WALK && c < hdr && c < brk_pos; n++) begin
      s = tag_rd(c) >> 3;
      if (s == 0) break;
      c += s;
    end
    if (c != hdr) return ST_IGN;
    hv = tag_rd(hdr);
    if ((hv >> 3) == 0) return ST_IGN;
    fv = tag_rd(hdr + (hv >> 3) - 4);
    if (hv != fv) return ST_IGN;
    if (!hv[0]) return ST_UNALLOC;
    tag_wr(hdr, tag_of(hv >> 3, 1'b0));
    tag_wr(hdr + (hv >> 3) - 4, tag_of(hv >> 3, 1'b0));
    merge_free(hdr);
    return ST_OK;
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned exp);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp);
    errors_o++;
  endtask

  // compare response words, then predict from request words
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_word_t w;
    if (!rst_ni) begin
      for (int i = 0; i < TAG_WORDS; i++) heap_tags[i] = '0;
      tag_wr(4, tag_of(8, 1'b1));
      tag_wr(8, tag_of(8, 1'b1));
      tag_wr(12, tag_of(0, 1'b1));
      brk_pos   = 12;
      walk_head = 12;
      lim_pos   = PAGE_BYTES * INITIAL_PAGES;
      errors_o  = 0;
      checked_o = 0;
      want_q.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        checked_o++;
        if (want_q.size() == 0) begin
          report("unexpected response word", rsp_i.status, 0);
        end else begin
          w = want_q.pop_front();
          if (rsp_i.payload_offset !== w.payload)
            report("payload_offset", rsp_i.payload_offset, w.payload);
          if (rsp_i.status !== w.st) report("status", rsp_i.status, w.st);
        end
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.func == FUNC_ALLOC) begin
          w = first_fit(req_i.request_bytes);
        end else begin
          w.payload = '0;
          w.st      = release_block(req_i.release_offset);
        end
        want_q.push_back(w);
      end
    end
  end

endmodule

[verif/tb_boundary_tag_first_fit_allocator.sv]
// Testbench top for the allocator: clock, reset, request stimulus, response
// back-pressure and verdict. Depends on btff_pkg, btff_tb_pkg, btff_if, btff_checker.
`timescale 1ns / 1ps

module tb_boundary_tag_first_fit_allocator;
  import btff_pkg::*;
  import btff_tb_pkg::*;

  localparam int unsigned RANDOM_WORDS = 830;
  localparam int unsigned IDLE_LIMIT   = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned errors, pending, checked;
  int unsigned n_alloc, n_free, n_rsp, idle_cycles;
  logic [15:0] live_q[$];
  logic [15:0] freed_q[$];

  btff_req_if req_if ();
  btff_rsp_if rsp_if ();

  boundary_tag_first_fit_allocator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  btff_checker checker_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_if),
    .rsp_i    (rsp_if),
    .errors_o (errors),
    .pending_o(pending),
    .checked_o(checked)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // one request word, then a random gap
  task automatic send_word(input logic fn, input logic [16:0] rq, input logic [15:0] off);
    int unsigned gap;
    req_if.valid          <= 1'b1;
    req_if.func           <= fn;
    req_if.request_bytes  <= rq;
    req_if.release_offset <= off;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (fn == FUNC_ALLOC) n_alloc++;
    else n_free++;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic alloc_word(input logic [16:0] rq);
    send_word(FUNC_ALLOC, rq, 16'($urandom));
  endtask

  task automatic free_word(input logic [15:0] off);
    send_word(FUNC_FREE, 17'($urandom), off);
  endtask

  task automatic free_live(input int unsigned idx);
    logic [15:0] off;
    off = live_q[idx];
    live_q.delete(idx);
    freed_q.push_back(off);
    if (freed_q.size() > 16) void'(freed_q.pop_front());
    free_word(off);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [16:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 17'($urandom_range(1, 64));
    if (r < 87) return 17'($urandom_range(65, 1024));
    if (r < 97) return 17'($urandom_range(1025, 8192));
    if (r < 98) return 17'd0;
    return 17'($urandom_range(8193, 65536));
  endfunction

  // remember offsets handed out
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_rsp++;
      if (rsp_if.status == ST_OK && rsp_if.payload_offset != 0)
        live_q.push_back(rsp_if.payload_offset);
    end
  end

  // response back-pressure, with one long hold-off
  initial begin
    bit held;
    bit rdy;
    int unsigned len;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && n_rsp >= 120) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      len = $urandom_range(1, 12);
      rdy = ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 29) == 0) begin
        rdy = 1'b0;
        len = $urandom_range(20, 80);
      end
      rsp_if.ready <= rdy;
      repeat (len) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_boundary_tag_first_fit_allocator: errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    idle_cycles = 0;
    n_alloc = 0;
    n_free  = 0;
    n_rsp   = 0;
    req_if.valid          <= 1'b0;
    req_if.func           <= FUNC_ALLOC;
    req_if.request_bytes  <= '0;
    req_if.release_offset <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero size, tiny, exact fit, page growth, exhaustion, bad frees
    alloc_word(17'd0);
    alloc_word(17'd1);
    alloc_word(17'd8);
    alloc_word(17'd4096);
    alloc_word(17'd65536);
    alloc_word(17'd65535);
    alloc_word(17'd40000);
    alloc_word(17'd30000);
    drain();
    free_word(16'd0);
    free_word(16'd3);
    free_word(16'd65535);
    free_word(16'd65528);
    free_word(16'd24);
    free_word(live_q[1]);
    free_word(live_q[1]);
    alloc_word(17'd8);
    alloc_word(17'd16);
    drain();
    free_live(0);
    drain();
    free_live(0);
    free_word(freed_q[freed_q.size() - 1]);
    alloc_word(17'd2);
    alloc_word(17'd100);
    alloc_word(17'd30000);
    drain();

    // random: mostly modest allocates and live frees, some broken frees
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) drain();
      if (live_q.size() == 0) begin
        r = 0;
      end else if (live_q.size() > 40) begin
        r = 80;
      end else begin
        r = $urandom_range(0, 99);
      end
      if (r < 55) begin
        alloc_word(pick_size());
        // the next free may need this offset
        if ($urandom_range(0, 3) == 0) drain();
      end else if (r < 88 && live_q.size() != 0) begin
        free_live($urandom_range(0, live_q.size() - 1));
      end else if (r < 94 && freed_q.size() != 0) begin
        free_word(freed_q[$urandom_range(0, freed_q.size() - 1)]);
      end else if (r < 97 && live_q.size() != 0) begin
        free_word(live_q[$urandom_range(0, live_q.size() - 1)] + 16'd8);
      end else begin
        free_word(16'($urandom));
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    $display("sent %0d allocates and %0d frees, %0d response words checked",
             n_alloc, n_free, checked);
    $display("covered zero size, exhaustion, page growth, merging and rejected frees");
    if (errors == 0) begin
      $display("tb_boundary_tag_first_fit_allocator: clean");
    end else begin
      $display("tb_boundary_tag_first_fit_allocator: errors");
    end
    $finish;
  end

endmodule
